@@ src/wmh_pkg.sv @@
// Package: sample type, field widths and defaults for the windowed min/max/median history.
`timescale 1ns / 1ps
package wmh_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WIN_W          = 7;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd16;
    localparam int V_W            = 16;
    localparam int C_W            = 16;
    localparam int P_W            = 19;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic        [V_W-1:0] v;
        logic signed [C_W-1:0] c;
        logic signed [P_W-1:0] p;
    } sample_t;

endpackage

@@ src/wmh_cell.sv @@
// One cell of the sample chain: holds a sample and passes it on when the chain shifts.
`timescale 1ns / 1ps
module wmh_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  wmh_pkg::sample_t din,
    output wmh_pkg::sample_t dout
);
    import wmh_pkg::*;

    sample_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

@@ src/windowed_minmax_median_history.sv @@
// Top level: sample chain plus rank-counting sequencer for min, max and median.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  in      | op voltage_mv current_ma power_mw         | in_valid / in_ready
//  out     | valid_res samples_used min/max/median ... | out_valid / out_ready
//  cfg     | cfg_wdata (window_len)                    | cfg_we, no wait
//
//  A clear or a zero-window push goes straight from idle to the done state.
//  For any other push, for each chain position the chain rotates once past
//  the candidate and the rank of that candidate is counted.
//  Reset empties the history; the chain contents stay undefined.
//  A result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module windowed_minmax_median_history #(
    parameter int CAPACITY = wmh_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [wmh_pkg::V_W-1:0]       voltage_mv,
    input  logic signed [wmh_pkg::C_W-1:0] current_ma,
    input  logic signed [wmh_pkg::P_W-1:0] power_mw,
    input  logic                          cfg_we,
    input  logic [wmh_pkg::WIN_W-1:0]     cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          valid_res,
    output logic [wmh_pkg::WIN_W-1:0]     samples_used,
    output logic signed [wmh_pkg::C_W-1:0] min_current,
    output logic signed [wmh_pkg::C_W-1:0] max_current,
    output logic [wmh_pkg::V_W-1:0]       max_voltage,
    output logic signed [wmh_pkg::P_W-1:0] max_power,
    output logic [wmh_pkg::V_W-1:0]       median_voltage,
    output logic signed [wmh_pkg::C_W-1:0] median_current,
    output logic signed [wmh_pkg::P_W-1:0] median_power
);
    import wmh_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_FIN, S_DONE} state_t;

    state_t            state_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     n_reg;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     step_reg;
    logic [IW-1:0]     outer_reg;
    sample_t           cand_reg;
    logic [IW-1:0]     cand_idx_reg;
    logic [CW-1:0]     rv_reg, rc_reg, rp_reg;
    logic signed [C_W-1:0] minc_reg, maxc_reg, loc_reg, hic_reg;
    logic [V_W-1:0]        maxv_reg, lov_reg, hiv_reg;
    logic signed [P_W-1:0] maxp_reg, lop_reg, hip_reg;
    logic              res_valid_reg;
    logic              out_valid_reg;
    logic              oval_reg;
    logic [WIN_W-1:0]  oused_reg;
    logic signed [C_W-1:0] ominc_reg, omaxc_reg, omedc_reg;
    logic [V_W-1:0]        omaxv_reg, omedv_reg;
    logic signed [P_W-1:0] omaxp_reg, omedp_reg;

    sample_t chain [CAPACITY];
    sample_t in_sample, head, chain_in;
    logic    accept, push, shift_en;
    logic    in_win, lt_v, lt_c, lt_p, tie_first, cand_in_win;
    logic [CW-1:0] lo_rank, hi_rank, count_inc, n_calc;
    logic [V_W:0]        sum_v;
    logic signed [C_W:0] sum_c;
    logic signed [P_W:0] sum_p;

    assign in_sample = '{v: voltage_mv, c: current_ma, p: power_mw};
    assign accept    = in_valid && in_ready;
    assign push      = accept && (op == OP_PUSH);
    assign head      = chain[CAPACITY-1];
    assign shift_en  = push || (state_reg == S_SCAN) || (state_reg == S_FIN);
    assign chain_in  = push ? in_sample : head;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                wmh_cell u_cell (.clk(clk), .shift_en(shift_en), .din(chain_in),
                                 .dout(chain[g]));
            end
            else
            begin : g_rest
                wmh_cell u_cell (.clk(clk), .shift_en(shift_en), .din(chain[g-1]),
                                 .dout(chain[g]));
            end
        end
    endgenerate

    assign count_inc = (count_reg == CAP_CNT) ? count_reg : count_reg + CW'(1);
    assign n_calc    = (32'(window_reg) < 32'(count_inc)) ? CW'(window_reg) : count_inc;
    assign lo_rank   = (n_reg - CW'(1)) >> 1;
    assign hi_rank   = n_reg >> 1;

    assign in_win      = 32'(idx_reg) < 32'(n_reg);
    assign cand_in_win = 32'(cand_idx_reg) < 32'(n_reg);
    assign tie_first   = idx_reg < cand_idx_reg;
    assign lt_v = (head.v < cand_reg.v) || ((head.v == cand_reg.v) && tie_first);
    assign lt_c = (head.c < cand_reg.c) || ((head.c == cand_reg.c) && tie_first);
    assign lt_p = (head.p < cand_reg.p) || ((head.p == cand_reg.p) && tie_first);

    assign sum_v = {1'b0, lov_reg} + {1'b0, hiv_reg};
    assign sum_c = {loc_reg[C_W-1], loc_reg} + {hic_reg[C_W-1], hic_reg};
    assign sum_p = {lop_reg[P_W-1], lop_reg} + {hip_reg[P_W-1], hip_reg};

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_valid_reg <= 1'b0;
                        if (op == OP_CLEAR)
                        begin
                            count_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            count_reg <= count_inc;
                            n_reg     <= n_calc;
                            idx_reg   <= LAST;
                            outer_reg <= '0;
                            minc_reg  <= {1'b0, {(C_W-1){1'b1}}};
                            maxc_reg  <= {1'b1, {(C_W-1){1'b0}}};
                            maxv_reg  <= '0;
                            maxp_reg  <= {1'b1, {(P_W-1){1'b0}}};
                            state_reg <= (window_reg == '0) ? S_DONE : S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    cand_reg     <= head;
                    cand_idx_reg <= idx_reg;
                    rv_reg       <= '0;
                    rc_reg       <= '0;
                    rp_reg       <= '0;
                    step_reg     <= '0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (in_win)
                    begin
                        rv_reg <= rv_reg + CW'(lt_v);
                        rc_reg <= rc_reg + CW'(lt_c);
                        rp_reg <= rp_reg + CW'(lt_p);
                        if (head.c < minc_reg) minc_reg <= head.c;
                        if (head.c > maxc_reg) maxc_reg <= head.c;
                        if (head.v > maxv_reg) maxv_reg <= head.v;
                        if (head.p > maxp_reg) maxp_reg <= head.p;
                    end
                    idx_reg  <= (idx_reg == '0) ? LAST : idx_reg - IW'(1);
                    step_reg <= step_reg + IW'(1);
                    if (step_reg == LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (cand_in_win)
                    begin
                        if (rv_reg == lo_rank) lov_reg <= cand_reg.v;
                        if (rv_reg == hi_rank) hiv_reg <= cand_reg.v;
                        if (rc_reg == lo_rank) loc_reg <= cand_reg.c;
                        if (rc_reg == hi_rank) hic_reg <= cand_reg.c;
                        if (rp_reg == lo_rank) lop_reg <= cand_reg.p;
                        if (rp_reg == hi_rank) hip_reg <= cand_reg.p;
                    end
                    idx_reg   <= (idx_reg == '0) ? LAST : idx_reg - IW'(1);
                    outer_reg <= outer_reg + IW'(1);
                    if (outer_reg == LAST)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        oval_reg      <= res_valid_reg;
                        if (res_valid_reg)
                        begin
                            oused_reg <= WIN_W'(n_reg);
                            ominc_reg <= minc_reg;
                            omaxc_reg <= maxc_reg;
                            omaxv_reg <= maxv_reg;
                            omaxp_reg <= maxp_reg;
                            omedv_reg <= sum_v[V_W:1];
                            omedc_reg <= sum_c[C_W:1];
                            omedp_reg <= sum_p[P_W:1];
                        end
                        else
                        begin
                            oused_reg <= '0;
                            ominc_reg <= '0;
                            omaxc_reg <= '0;
                            omaxv_reg <= '0;
                            omaxp_reg <= '0;
                            omedv_reg <= '0;
                            omedc_reg <= '0;
                            omedp_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = oval_reg;
    assign samples_used   = oused_reg;
    assign min_current    = ominc_reg;
    assign max_current    = omaxc_reg;
    assign max_voltage    = omaxv_reg;
    assign max_power      = omaxp_reg;
    assign median_voltage = omedv_reg;
    assign median_current = omedc_reg;
    assign median_power   = omedp_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("stored count above capacity");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("item accepted while busy");
    a_scan_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && step_reg == LAST |=> state_reg == S_FIN)
        else $error("rotation length wrong");

endmodule
